// ----- rtl/rgbe_pkg.sv -----
// rgbe_pkg: shared types and constants for the rgbe to gamma byte converter
// no dependencies; used by the top, front and back modules under rtl
package rgbe_pkg;

	// field widths fixed by the item format
	localparam int BYTE_W = 8;
	localparam int ROW_W  = 5;
	localparam int COL_W  = 8;
	localparam int NUM_CH = 3;

	// channel lanes
	localparam int CH_RED   = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 2;

	// exponent handling
	localparam int EXP_BIAS     = 128;
	localparam int UP_SHIFT_MAX = 8;

	localparam logic [BYTE_W-1:0] ZERO_BYTE = 8'h00;
	localparam logic [BYTE_W-1:0] SAT_BYTE  = 8'hFF;

	typedef enum logic {
		OP_CONVERT = 1'b0,
		OP_WRITE   = 1'b1
	} op_t;

	// what the back end does for one channel
	typedef enum logic [1:0] {
		CH_ZERO  = 2'd0,
		CH_SAT   = 2'd1,
		CH_TABLE = 2'd2
	} ch_kind_t;

	typedef struct packed {
		ch_kind_t          kind;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
	} ch_cmd_t;

	// classified item handed from front to back
	typedef struct packed {
		op_t                      op;
		logic                     last;
		logic [ROW_W-1:0]         wr_row;
		logic [COL_W-1:0]         wr_col;
		logic [BYTE_W-1:0]        wr_value;
		ch_cmd_t [NUM_CH-1:0]     ch;
	} cmd_t;

	// one converted pixel
	typedef struct packed {
		logic                           last;
		logic [NUM_CH-1:0][BYTE_W-1:0]  pix;
	} res_t;

endpackage

// ----- rtl/rgbe_to_gamma_bytes_unit.sv -----
// rgbe_to_gamma_bytes_unit: top level, rgbe pixels to gamma-corrected display bytes
// depends on rgbe_pkg, rgbe_front, rgbe_fifo, rgbe_back
//
//   channel | handshake    | payload
//   --------+--------------+---------------------------------------------------
//   input   | push / full  | opcode, mantissas, shared_exponent, last_pixel,
//           |              | table_row, table_column, table_value
//   result  | pop / empty  | out_red, out_green, out_blue, out_last
//
// one item is taken per cycle while full is low; a convert result passes cmdq, the
// read stage and resq, bounded by one table read per channel per cycle
// reset clears queues and stage valid; table contents stay undefined until written
// full rises when the command queue holds CMDQ_DEPTH items; the back end stalls
// when all result slots are filled or reserved, table writes still drain
module rgbe_to_gamma_bytes_unit #(
	parameter int MAX_SHIFT  = 31,
	parameter int CMDQ_DEPTH = 4,
	parameter int RESQ_DEPTH = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic                        opcode,
	input  logic [rgbe_pkg::BYTE_W-1:0] red_mantissa,
	input  logic [rgbe_pkg::BYTE_W-1:0] green_mantissa,
	input  logic [rgbe_pkg::BYTE_W-1:0] blue_mantissa,
	input  logic [rgbe_pkg::BYTE_W-1:0] shared_exponent,
	input  logic                        last_pixel,
	input  logic [rgbe_pkg::ROW_W-1:0]  table_row,
	input  logic [rgbe_pkg::COL_W-1:0]  table_column,
	input  logic [rgbe_pkg::BYTE_W-1:0] table_value,
	output logic                        empty,
	input  logic                        pop,
	output logic [rgbe_pkg::BYTE_W-1:0] out_red,
	output logic [rgbe_pkg::BYTE_W-1:0] out_green,
	output logic [rgbe_pkg::BYTE_W-1:0] out_blue,
	output logic                        out_last
);

	localparam int CQW = $clog2(CMDQ_DEPTH + 1);
	localparam int RQW = $clog2(RESQ_DEPTH + 1);

	logic            cmdq_full;
	logic            cmdq_empty;
	logic            cmd_push;
	logic            cmd_pop;
	logic [CQW-1:0]  cmdq_count;
	rgbe_pkg::cmd_t  cmd_in;
	rgbe_pkg::cmd_t  cmd_out;
	logic            res_push;
	logic            resq_full;
	logic [RQW-1:0]  resq_count;
	rgbe_pkg::res_t  res_in;
	rgbe_pkg::res_t  res_out;

	// front end: transfer in and classify
	rgbe_front #(.MAX_SHIFT(MAX_SHIFT)) u_front (
		.push            (push),
		.full            (full),
		.opcode          (opcode),
		.red_mantissa    (red_mantissa),
		.green_mantissa  (green_mantissa),
		.blue_mantissa   (blue_mantissa),
		.shared_exponent (shared_exponent),
		.last_pixel      (last_pixel),
		.table_row       (table_row),
		.table_column    (table_column),
		.table_value     (table_value),
		.cmdq_full       (cmdq_full),
		.cmd_push        (cmd_push),
		.cmd             (cmd_in)
	);

	// queue between front and back
	rgbe_fifo #(.T(rgbe_pkg::cmd_t), .DEPTH(CMDQ_DEPTH)) u_cmdq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (cmd_push),
		.wr_data (cmd_in),
		.full    (cmdq_full),
		.rd      (cmd_pop),
		.rd_data (cmd_out),
		.empty   (cmdq_empty),
		.count   (cmdq_count)
	);

	// back end: table access
	rgbe_back #(.MAX_SHIFT(MAX_SHIFT), .RESQ_DEPTH(RESQ_DEPTH)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (!cmdq_empty),
		.cmd        (cmd_out),
		.cmd_pop    (cmd_pop),
		.resq_count (resq_count),
		.res_push   (res_push),
		.res        (res_in)
	);

	// result queue towards the consumer
	rgbe_fifo #(.T(rgbe_pkg::res_t), .DEPTH(RESQ_DEPTH)) u_resq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (res_push),
		.wr_data (res_in),
		.full    (resq_full),
		.rd      (pop && !empty),
		.rd_data (res_out),
		.empty   (empty),
		.count   (resq_count)
	);

	assign out_red   = res_out.pix[rgbe_pkg::CH_RED];
	assign out_green = res_out.pix[rgbe_pkg::CH_GREEN];
	assign out_blue  = res_out.pix[rgbe_pkg::CH_BLUE];
	assign out_last  = res_out.last;

	// command queue level matches its full flag
	a_cmdq_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmdq_full == (cmdq_count == CQW'(CMDQ_DEPTH)))
		else $error("rgbe_to_gamma_bytes_unit: command queue level mismatch");
	// a finished pixel never meets a full result queue
	a_resq_slot: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !resq_full)
		else $error("rgbe_to_gamma_bytes_unit: result pushed into full queue");
	// a waiting result holds until its transfer
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(res_out)))
		else $error("rgbe_to_gamma_bytes_unit: waiting result changed");

endmodule

// ----- rtl/rgbe_fifo.sv -----
// rgbe_fifo: small register queue used for the command and result queues
// depends on nothing but the element type passed in
module rgbe_fifo #(
	parameter type T     = logic,
	parameter int  DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr,
	input  T                           wr_data,
	output logic                       full,
	input  logic                       rd,
	output T                           rd_data,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	T                store_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	// storage, payload only
	always_ff @(posedge clk) begin
		if (wr) begin
			store_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				if (wr_ptr_q == PW'(DEPTH - 1)) begin
					wr_ptr_q <= '0;
				end else begin
					wr_ptr_q <= wr_ptr_q + PW'(1);
				end
			end
			if (rd) begin
				if (rd_ptr_q == PW'(DEPTH - 1)) begin
					rd_ptr_q <= '0;
				end else begin
					rd_ptr_q <= rd_ptr_q + PW'(1);
				end
			end
			if (wr && !rd) begin
				count_q <= count_q + CW'(1);
			end else if (rd && !wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	assign rd_data = store_q[rd_ptr_q];
	assign empty   = (count_q == '0);
	assign full    = (count_q == CW'(DEPTH));
	assign count   = count_q;

	// no transfer in beyond capacity, none out of an empty queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr && !rd && count_q == CW'(DEPTH)))
		else $error("rgbe_fifo: write into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd && count_q == '0))
		else $error("rgbe_fifo: read from empty queue");
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("rgbe_fifo: fill level out of range");

endmodule

// ----- rtl/rgbe_front.sv -----
// rgbe_front: accepts input items and classifies each pixel channel by exponent range
// depends on rgbe_pkg; feeds the command queue
module rgbe_front #(
	parameter int MAX_SHIFT = 31
) (
	input  logic                        push,
	output logic                        full,
	input  logic                        opcode,
	input  logic [rgbe_pkg::BYTE_W-1:0] red_mantissa,
	input  logic [rgbe_pkg::BYTE_W-1:0] green_mantissa,
	input  logic [rgbe_pkg::BYTE_W-1:0] blue_mantissa,
	input  logic [rgbe_pkg::BYTE_W-1:0] shared_exponent,
	input  logic                        last_pixel,
	input  logic [rgbe_pkg::ROW_W-1:0]  table_row,
	input  logic [rgbe_pkg::COL_W-1:0]  table_column,
	input  logic [rgbe_pkg::BYTE_W-1:0] table_value,
	input  logic                        cmdq_full,
	output logic                        cmd_push,
	output rgbe_pkg::cmd_t              cmd
);

	// biased exponent bounds of each range
	localparam logic [7:0] EXP_ZERO_LIM  = 8'(rgbe_pkg::EXP_BIAS - MAX_SHIFT - 8);
	localparam logic [7:0] EXP_RND_TOP   = 8'(rgbe_pkg::EXP_BIAS - MAX_SHIFT - 1);
	localparam logic [7:0] EXP_DIRECT_LO = 8'(rgbe_pkg::EXP_BIAS - MAX_SHIFT);
	localparam logic [7:0] EXP_ONE       = 8'(rgbe_pkg::EXP_BIAS);
	localparam logic [7:0] EXP_UP_LO     = 8'(rgbe_pkg::EXP_BIAS + 1);
	localparam logic [7:0] EXP_UP_HI     = 8'(rgbe_pkg::EXP_BIAS + rgbe_pkg::UP_SHIFT_MAX);
	localparam logic [rgbe_pkg::ROW_W-1:0] LAST_ROW = rgbe_pkg::ROW_W'(MAX_SHIFT);

	// per channel path choice and table address
	function automatic rgbe_pkg::ch_cmd_t classify(input logic [7:0] m, input logic [7:0] x);
		rgbe_pkg::ch_cmd_t c;
		logic [7:0]  kd;
		logic [7:0]  sd;
		logic [7:0]  dd;
		logic [8:0]  rnd;
		logic [15:0] v;
		kd  = EXP_RND_TOP - x;
		sd  = x - EXP_UP_LO;
		dd  = EXP_ONE - x;
		rnd = {1'b0, m >> kd[2:0]} + 9'd1;
		v   = 16'({m, 1'b1}) << sd[2:0];
		c.kind = rgbe_pkg::CH_TABLE;
		c.row  = '0;
		c.col  = m;
		priority if (x < EXP_ZERO_LIM) begin
			c.kind = rgbe_pkg::CH_ZERO;
		end else if (x < EXP_DIRECT_LO) begin
			// rounded right shift into the last row
			c.row = LAST_ROW;
			c.col = rnd[8:1];
		end else if (x <= EXP_ONE) begin
			c.row = dd[rgbe_pkg::ROW_W-1:0];
		end else if (x <= EXP_UP_HI) begin
			// left shift, saturating once past one byte
			if (v[15:8] != 8'd0) begin
				c.kind = rgbe_pkg::CH_SAT;
			end else begin
				c.col = v[7:0];
			end
		end else begin
			c.kind = rgbe_pkg::CH_SAT;
		end
		return c;
	endfunction

	logic write_item;
	logic row_beyond;

	// writes to rows past the table are taken and dropped
	assign write_item = (rgbe_pkg::op_t'(opcode) == rgbe_pkg::OP_WRITE);
	assign row_beyond = (table_row > LAST_ROW);
	assign full       = cmdq_full;
	assign cmd_push   = push && !cmdq_full && !(write_item && row_beyond);

	// command build
	always_comb begin
		cmd.op       = rgbe_pkg::op_t'(opcode);
		cmd.last     = last_pixel;
		cmd.wr_row   = table_row;
		cmd.wr_col   = table_column;
		cmd.wr_value = table_value;
		cmd.ch[rgbe_pkg::CH_RED]   = classify(red_mantissa, shared_exponent);
		cmd.ch[rgbe_pkg::CH_GREEN] = classify(green_mantissa, shared_exponent);
		cmd.ch[rgbe_pkg::CH_BLUE]  = classify(blue_mantissa, shared_exponent);
	end

endmodule

// ----- rtl/rgbe_back.sv -----
// rgbe_back: carries out table writes and per channel table reads
// depends on rgbe_pkg; pops the command queue, pushes the result queue
module rgbe_back #(
	parameter int MAX_SHIFT  = 31,
	parameter int RESQ_DEPTH = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cmd_valid,
	input  rgbe_pkg::cmd_t                  cmd,
	output logic                            cmd_pop,
	input  logic [$clog2(RESQ_DEPTH+1)-1:0] resq_count,
	output logic                            res_push,
	output rgbe_pkg::res_t                  res
);

	localparam int ROWS  = MAX_SHIFT + 1;
	localparam int RW    = $clog2(ROWS);
	localparam int AW    = RW + rgbe_pkg::COL_W;
	localparam int DEPTH = ROWS * (2 ** rgbe_pkg::COL_W);
	localparam int CW    = $clog2(RESQ_DEPTH + 1);

	logic                  is_write;
	logic                  room;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic                  valid_s1;
	logic                  last_s1;
	rgbe_pkg::ch_kind_t    kind_s1 [rgbe_pkg::NUM_CH];
	logic [rgbe_pkg::BYTE_W-1:0] rd_data_s1 [rgbe_pkg::NUM_CH];

	// issue: writes always go, converts need a free result slot
	assign is_write = (cmd.op == rgbe_pkg::OP_WRITE);
	assign room     = ({1'b0, resq_count} + (CW+1)'(valid_s1)) < (CW+1)'(RESQ_DEPTH);
	assign cmd_pop  = cmd_valid && (is_write || room);
	assign wr_en    = cmd_pop && is_write;
	assign wr_addr  = {cmd.wr_row[RW-1:0], cmd.wr_col};

	// one table copy per channel, same writes, own read port
	for (genvar c = 0; c < rgbe_pkg::NUM_CH; c++) begin : g_ch
		logic [rgbe_pkg::BYTE_W-1:0] corr_mem_q [DEPTH];
		logic [AW-1:0]               rd_addr;
		logic                        rd_en;

		assign rd_addr = {cmd.ch[c].row[RW-1:0], cmd.ch[c].col};
		assign rd_en   = cmd_pop && !is_write && (cmd.ch[c].kind == rgbe_pkg::CH_TABLE);

		always_ff @(posedge clk) begin
			if (wr_en) begin
				corr_mem_q[wr_addr] <= cmd.wr_value;
			end
			if (rd_en) begin
				rd_data_s1[c] <= corr_mem_q[rd_addr];
			end
		end

		always_ff @(posedge clk) begin
			if (cmd_pop) begin
				kind_s1[c] <= cmd.ch[c].kind;
			end
		end

		// final byte selection
		always_comb begin
			unique case (kind_s1[c])
				rgbe_pkg::CH_ZERO:  res.pix[c] = rgbe_pkg::ZERO_BYTE;
				rgbe_pkg::CH_SAT:   res.pix[c] = rgbe_pkg::SAT_BYTE;
				rgbe_pkg::CH_TABLE: res.pix[c] = rd_data_s1[c];
				default:            res.pix[c] = rgbe_pkg::ZERO_BYTE;
			endcase
		end
	end

	// stage valid for converts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd_pop && !is_write;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			last_s1 <= cmd.last;
		end
	end

	assign res.last = last_s1;
	assign res_push = valid_s1;

	// a result in flight always finds a free slot
	a_slot_reserved: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (resq_count < CW'(RESQ_DEPTH)))
		else $error("rgbe_back: result without a reserved slot");
	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_pop && is_write) |=> !valid_s1)
		else $error("rgbe_back: table write produced a result");

endmodule
